[src/qse_pkg.sv]
// ----------------------------------------------------------------------------
// qse_pkg: shared constants for the quicksort engine
// Sizes of the element store, the range stack and the key, plus the
// command and status codes carried with each beat.
// ----------------------------------------------------------------------------
package qse_pkg;

  localparam int MAX_ELEMENTS = 256;
  localparam int KEY_WIDTH    = 32;

  // Store addressing and element counts (a count must be able to hold the depth).
  localparam int ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = ADDR_W + 1;

  // Only the larger side is pushed, so the stack never grows past log2 of the depth.
  localparam int STACK_SLOTS = ADDR_W + 1;
  localparam int SP_W        = $clog2(STACK_SLOTS + 1);
  localparam int STK_IDX_W   = $clog2(STACK_SLOTS);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

[src/quicksort_engine_top.sv]
// ----------------------------------------------------------------------------
// quicksort_engine_top: in-place quicksort engine
// Loads keys, sorts them with a Lomuto-partition quicksort, and returns
// them in ascending order one read at a time.
// ----------------------------------------------------------------------------
// A command beat is taken at a rising edge where start is high and busy is
// low. Every command produces exactly one result beat, shown for a single
// cycle with out_strobe high; the receiver cannot stall it, so it must take
// each result beat as it appears. A load without load_last and any read
// leave the engine idle; the result beat shows right after the accepting
// edge and is taken at the next edge. Such commands may be issued every
// cycle. A load with load_last starts the sort and holds busy
// high until the sort is done, then the result beat of that load appears.
// The sort runs on one store read port, one write port and one comparator
// under a small sequencer: each partition reads the middle and last keys
// and swaps them so that the pivot sits last, scans the range and moves
// each key below the pivot down to the split point, puts the pivot into
// its slot, then splits the range and picks the next one. signed_keys is
// written through cfg_wr_en and cfg_wr_data and selects unsigned or two's
// complement signed key order; write it only while the engine is idle.
// ----------------------------------------------------------------------------
module quicksort_engine_top
  import qse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration port.
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  // Command channel.
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  logic [KEY_WIDTH-1:0] in_key_value,
  input  logic                 in_load_last,
  // Result channel.
  output logic                 out_strobe,
  output logic [KEY_WIDTH-1:0] out_sorted_value,
  output logic                 out_is_final,
  output logic [1:0]           out_status
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_RD_MID   = 4'd2;
  localparam logic [3:0] S_RD_LAST  = 4'd3;
  localparam logic [3:0] S_WR_A     = 4'd4;
  localparam logic [3:0] S_WR_B     = 4'd5;
  localparam logic [3:0] S_SCAN_RD  = 4'd6;
  localparam logic [3:0] S_SCAN_CMP = 4'd7;
  localparam logic [3:0] S_SW_A     = 4'd8;
  localparam logic [3:0] S_SW_B     = 4'd9;
  localparam logic [3:0] S_FIN_RD   = 4'd10;
  localparam logic [3:0] S_FIN_A    = 4'd11;
  localparam logic [3:0] S_FIN_B    = 4'd12;
  localparam logic [3:0] S_SPLIT    = 4'd13;

  logic [3:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     rpos_r, rpos_nxt;
  logic                 sorted_r, sorted_nxt;
  logic                 signed_r;

  // Current range and partition scan pointers.
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [ADDR_W-1:0]    i_r, i_nxt;
  logic [ADDR_W-1:0]    sa_r, sa_nxt;
  logic [KEY_WIDTH-1:0] pivot_r, pivot_nxt;
  logic [KEY_WIDTH-1:0] cur_r, cur_nxt;

  // Range stack.
  logic [CNT_W-1:0]     stk_lo_r [STACK_SLOTS];
  logic [CNT_W-1:0]     stk_n_r  [STACK_SLOTS];
  logic [SP_W-1:0]      sp_r, sp_nxt;
  logic [SP_W-1:0]      sp_dec;
  logic                 push;
  logic [CNT_W-1:0]     push_lo, push_n;

  // Result beat registers.
  logic                 resp_valid_r, resp_valid_nxt;
  logic [1:0]           resp_status_r, resp_status_nxt;
  logic                 resp_final_r, resp_final_nxt;
  logic                 resp_rd_r, resp_rd_nxt;
  logic [1:0]           load_status_r, load_status_nxt;

  // Store port and comparator.
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [KEY_WIDTH-1:0] mem_wdata, mem_rdata;
  logic                 key_less;

  logic [ADDR_W-1:0]    last_idx, mid_idx;
  logic [CNT_W-1:0]     left_n, right_lo, right_n;
  logic [CNT_W-1:0]     eff_count, load_count;
  logic [1:0]           load_status;
  logic                 accept;

  qse_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  qse_cmp u_cmp (
    .signed_keys (signed_r),
    .key_a       (mem_rdata),
    .key_b       (pivot_r),
    .a_less      (key_less)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign last_idx = ADDR_W'(lo_r + n_r - CNT_W'(1));
  assign mid_idx  = ADDR_W'(lo_r + (n_r >> 1));

  // Split of the finished partition around the pivot slot.
  assign left_n   = {1'b0, sa_r} - lo_r;
  assign right_lo = {1'b0, sa_r} + CNT_W'(1);
  assign right_n  = {1'b0, last_idx} - {1'b0, sa_r};

  // A load after a finished sort starts a new set.
  assign eff_count = sorted_r ? '0 : count_r;
  assign sp_dec    = sp_r - SP_W'(1);

  always_comb begin
    if (eff_count < CNT_W'(MAX_ELEMENTS)) begin
      load_count  = eff_count + CNT_W'(1);
      load_status = STATUS_OK;
    end else begin
      load_count  = eff_count;
      load_status = STATUS_FULL;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    rpos_nxt        = rpos_r;
    sorted_nxt      = sorted_r;
    lo_nxt          = lo_r;
    n_nxt           = n_r;
    i_nxt           = i_r;
    sa_nxt          = sa_r;
    pivot_nxt       = pivot_r;
    cur_nxt         = cur_r;
    sp_nxt          = sp_r;
    push            = 1'b0;
    push_lo         = lo_r;
    push_n          = left_n;
    resp_valid_nxt  = 1'b0;
    resp_status_nxt = STATUS_OK;
    resp_final_nxt  = 1'b0;
    resp_rd_nxt     = 1'b0;
    load_status_nxt = load_status_r;
    mem_we          = 1'b0;
    mem_waddr       = eff_count[ADDR_W-1:0];
    mem_wdata       = in_key_value;
    mem_raddr       = rpos_r[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_LOAD) begin
            mem_we    = (load_status == STATUS_OK);
            count_nxt = load_count;
            if (sorted_r) begin
              sorted_nxt = 1'b0;
              rpos_nxt   = '0;
            end
            if (in_load_last) begin
              load_status_nxt = load_status;
              lo_nxt          = '0;
              n_nxt           = load_count;
              sp_nxt          = '0;
              state_nxt       = S_DISPATCH;
            end else begin
              resp_valid_nxt  = 1'b1;
              resp_status_nxt = load_status;
            end
          end else begin
            resp_valid_nxt = 1'b1;
            if (!sorted_r || rpos_r >= count_r) begin
              resp_status_nxt = STATUS_EMPTY;
            end else begin
              resp_rd_nxt    = 1'b1;
              resp_final_nxt = (rpos_r + CNT_W'(1) == count_r);
              rpos_nxt       = rpos_r + CNT_W'(1);
            end
          end
        end
      end
      S_DISPATCH: begin
        if (n_r > CNT_W'(1)) begin
          state_nxt = S_RD_MID;
        end else if (sp_r != '0) begin
          lo_nxt = stk_lo_r[sp_dec[STK_IDX_W-1:0]];
          n_nxt  = stk_n_r[sp_dec[STK_IDX_W-1:0]];
          sp_nxt = sp_dec;
        end else begin
          sorted_nxt      = 1'b1;
          rpos_nxt        = '0;
          resp_valid_nxt  = 1'b1;
          resp_status_nxt = load_status_r;
          state_nxt       = S_IDLE;
        end
      end
      S_RD_MID: begin
        mem_raddr = mid_idx;
        state_nxt = S_RD_LAST;
      end
      S_RD_LAST: begin
        mem_raddr = last_idx;
        pivot_nxt = mem_rdata;
        state_nxt = S_WR_A;
      end
      S_WR_A: begin
        // Old last key goes to the middle slot.
        mem_we    = 1'b1;
        mem_waddr = mid_idx;
        mem_wdata = mem_rdata;
        state_nxt = S_WR_B;
      end
      S_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = last_idx;
        mem_wdata = pivot_r;
        i_nxt     = lo_r[ADDR_W-1:0];
        sa_nxt    = lo_r[ADDR_W-1:0];
        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        mem_raddr = i_r;
        if (i_r == last_idx) begin
          state_nxt = S_FIN_RD;
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        cur_nxt   = mem_rdata;
        mem_raddr = sa_r;
        if (key_less && sa_r != i_r) begin
          state_nxt = S_SW_A;
        end else begin
          if (key_less) begin
            sa_nxt = sa_r + ADDR_W'(1);
          end
          i_nxt     = i_r + ADDR_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_SW_A: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = mem_rdata;
        state_nxt = S_SW_B;
      end
      S_SW_B: begin
        mem_we    = 1'b1;
        mem_waddr = sa_r;
        mem_wdata = cur_r;
        sa_nxt    = sa_r + ADDR_W'(1);
        i_nxt     = i_r + ADDR_W'(1);
        state_nxt = S_SCAN_RD;
      end
      S_FIN_RD: begin
        mem_raddr = sa_r;
        state_nxt = S_FIN_A;
      end
      S_FIN_A: begin
        mem_we    = 1'b1;
        mem_waddr = last_idx;
        mem_wdata = mem_rdata;
        state_nxt = S_FIN_B;
      end
      S_FIN_B: begin
        mem_we    = 1'b1;
        mem_waddr = sa_r;
        mem_wdata = pivot_r;
        state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        // Continue on the smaller side; the larger side waits on the stack.
        if (left_n < right_n) begin
          push_lo = right_lo;
          push_n  = right_n;
          n_nxt   = left_n;
        end else begin
          push_lo = lo_r;
          push_n  = left_n;
          lo_nxt  = right_lo;
          n_nxt   = right_n;
        end
        if (push_n > CNT_W'(1) && sp_r < SP_W'(STACK_SLOTS)) begin
          push   = 1'b1;
          sp_nxt = sp_r + SP_W'(1);
        end
        state_nxt = S_DISPATCH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      rpos_r        <= '0;
      sorted_r      <= 1'b0;
      signed_r      <= 1'b0;
      sp_r          <= '0;
      resp_valid_r  <= 1'b0;
      resp_status_r <= STATUS_OK;
      resp_final_r  <= 1'b0;
      resp_rd_r     <= 1'b0;
      load_status_r <= STATUS_OK;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      rpos_r        <= rpos_nxt;
      sorted_r      <= sorted_nxt;
      sp_r          <= sp_nxt;
      resp_valid_r  <= resp_valid_nxt;
      resp_status_r <= resp_status_nxt;
      resp_final_r  <= resp_final_nxt;
      resp_rd_r     <= resp_rd_nxt;
      load_status_r <= load_status_nxt;
      if (cfg_wr_en) begin
        signed_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    sa_r    <= sa_nxt;
    pivot_r <= pivot_nxt;
    cur_r   <= cur_nxt;
    if (push) begin
      stk_lo_r[sp_r[STK_IDX_W-1:0]] <= push_lo;
      stk_n_r[sp_r[STK_IDX_W-1:0]]  <= push_n;
    end
  end

  // The store's registered read data lines up with the result beat of a read.
  assign out_strobe       = resp_valid_r;
  assign out_sorted_value = resp_rd_r ? mem_rdata : '0;
  assign out_is_final     = resp_final_r;
  assign out_status       = resp_status_r;

endmodule

[src/qse_mem.sv]
// ----------------------------------------------------------------------------
// qse_mem: element store
// Single write port and single read port; the read data is registered.
// ----------------------------------------------------------------------------
module qse_mem
  import qse_pkg::*;
(
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  logic [KEY_WIDTH-1:0] wdata,
  input  logic [ADDR_W-1:0]    raddr,
  output logic [KEY_WIDTH-1:0] rdata
);

  logic [KEY_WIDTH-1:0] mem [MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/qse_cmp.sv]
// ----------------------------------------------------------------------------
// qse_cmp: key comparator
// Strict less-than on two keys, unsigned or two's complement signed.
// ----------------------------------------------------------------------------
module qse_cmp
  import qse_pkg::*;
(
  input  logic                 signed_keys,
  input  logic [KEY_WIDTH-1:0] key_a,
  input  logic [KEY_WIDTH-1:0] key_b,
  output logic                 a_less
);

  logic [KEY_WIDTH-1:0] flip;

  // Flipping the sign bit maps signed order onto unsigned order.
  assign flip   = {signed_keys, {(KEY_WIDTH-1){1'b0}}};
  assign a_less = (key_a ^ flip) < (key_b ^ flip);

endmodule

[tb/sv/qse_tb_pkg.sv]
// ----------------------------------------------------------------------------
// qse_tb_pkg: shared testbench definitions for the quicksort engine
// The layout of one result beat, used by the checker.
// ----------------------------------------------------------------------------
package qse_tb_pkg;
  import qse_pkg::*;

  typedef struct packed {
    logic [KEY_WIDTH-1:0] sorted_value;
    logic                 is_final;
    logic [1:0]           status;
  } result_beat_t;

endpackage

[tb/sv/qse_checker.sv]
// ----------------------------------------------------------------------------
// qse_checker: result predictor and scoreboard for the quicksort engine
// Watches the command, result and configuration ports, keeps its own
// copy of the element store, and compares every result beat in order.
// ----------------------------------------------------------------------------
module qse_checker
  import qse_pkg::*;
  import qse_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_command,
  input  logic [KEY_WIDTH-1:0] in_key_value,
  input  logic                 in_load_last,
  input  logic                 out_strobe,
  input  logic [KEY_WIDTH-1:0] out_sorted_value,
  input  logic                 out_is_final,
  input  logic [1:0]           out_status,
  output int                   fail_count,
  output int                   pending_beats
);

  logic [KEY_WIDTH-1:0] store_copy [MAX_ELEMENTS];
  int unsigned          key_count;
  int unsigned          read_idx;
  bit                   set_ready;
  bit                   signed_order;
  result_beat_t         expected_beats [$];

  function automatic bit key_precedes(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
    logic [KEY_WIDTH-1:0] flip;
    flip = signed_order ? {1'b1, {(KEY_WIDTH-1){1'b0}}} : '0;
    return (a ^ flip) < (b ^ flip);
  endfunction

  function automatic void swap_elements(int unsigned x, int unsigned y);
    logic [KEY_WIDTH-1:0] held;
    held          = store_copy[x];
    store_copy[x] = store_copy[y];
    store_copy[y] = held;
  endfunction

  // Lomuto split of [lo, lo+n) around its middle element; returns the pivot offset.
  function automatic int unsigned partition_span(int unsigned lo, int unsigned n);
    int unsigned last_i;
    int unsigned dst;
    last_i = lo + n - 1;
    dst    = lo;
    swap_elements(lo + n / 2, last_i);
    for (int unsigned i = lo; i < last_i; i++) begin
      if (key_precedes(store_copy[i], store_copy[last_i])) begin
        swap_elements(i, dst);
        dst++;
      end
    end
    swap_elements(dst, last_i);
    return dst - lo;
  endfunction

  // Work on the smaller side, park the larger one on the span stack.
  function automatic void sort_elements();
    int unsigned span_lo [64];
    int unsigned span_len [64];
    int unsigned lo, n, p, depth, right_lo, right_n, big_lo, big_n;
    bit          done;
    lo    = 0;
    n     = key_count;
    depth = 0;
    done  = 1'b0;
    while (!done) begin
      if (n > 1) begin
        p        = partition_span(lo, n);
        right_lo = lo + p + 1;
        right_n  = n - p - 1;
        if (p < right_n) begin
          big_lo = right_lo;
          big_n  = right_n;
          n      = p;
        end else begin
          big_lo = lo;
          big_n  = p;
          lo     = right_lo;
          n      = right_n;
        end
        if (big_n > 1 && depth < 64) begin
          span_lo[depth]  = big_lo;
          span_len[depth] = big_n;
          depth++;
        end
      end else if (depth > 0) begin
        depth--;
        lo = span_lo[depth];
        n  = span_len[depth];
      end else begin
        done = 1'b1;
      end
    end
  endfunction

  function automatic result_beat_t predict_result(logic cmd, logic [KEY_WIDTH-1:0] key,
                                                  logic last);
    result_beat_t beat;
    beat = '{sorted_value: '0, is_final: 1'b0, status: STATUS_OK};
    if (cmd == CMD_LOAD) begin
      if (set_ready) begin
        set_ready = 1'b0;
        key_count = 0;
        read_idx  = 0;
      end
      if (key_count < MAX_ELEMENTS) begin
        store_copy[key_count] = key;
        key_count++;
      end else begin
        beat.status = STATUS_FULL;
      end
      if (last) begin
        sort_elements();
        set_ready = 1'b1;
        read_idx  = 0;
      end
    end else begin
      if (!set_ready || read_idx >= key_count) begin
        beat.status = STATUS_EMPTY;
      end else begin
        beat.sorted_value = store_copy[read_idx];
        beat.is_final     = (read_idx + 1 == key_count);
        read_idx++;
      end
    end
    return beat;
  endfunction

  task automatic note_mismatch(string field, logic [KEY_WIDTH-1:0] want,
                               logic [KEY_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_beat_t want;
    if (!rst_n) begin
      expected_beats.delete();
      key_count     = 0;
      read_idx      = 0;
      set_ready     = 1'b0;
      signed_order  = 1'b0;
      pending_beats <= 0;
    end else begin
      if (cfg_wr_en) begin
        signed_order = cfg_wr_data;
      end
      if (out_strobe) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing, actual %h/%b/%h",
                   $time, out_sorted_value, out_is_final, out_status);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          note_mismatch("sorted_value", want.sorted_value, out_sorted_value);
          note_mismatch("is_final", KEY_WIDTH'(want.is_final), KEY_WIDTH'(out_is_final));
          note_mismatch("status", KEY_WIDTH'(want.status), KEY_WIDTH'(out_status));
        end
      end
      if (start && !busy) begin
        expected_beats.push_back(predict_result(in_command, in_key_value, in_load_last));
      end
      pending_beats <= expected_beats.size();
    end
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb: stimulus top for the quicksort engine
// Drives directed and random load/read command beats with bursty gaps,
// switches the key order between phases, and reports the verdict from
// the checker's failure and pending beat counts.
// ----------------------------------------------------------------------------
module tb
  import qse_pkg::*;
  import qse_tb_pkg::*;
();

  // The run is cut off here no matter what; a few quadratic full-store sorts
  // plus all the small sets fit many times over.
  localparam longint RUN_LIMIT     = 64'd30_000_000;
  // Bound on the final drain once every command beat has been accepted.
  localparam int     DRAIN_LIMIT   = 400_000;
  // Random small sets run until this many command beats have gone out.
  localparam int     RANDOM_TARGET = 300;

  typedef enum {KEYS_RANDOM, KEYS_FEW, KEYS_RISING, KEYS_FALLING, KEYS_NEAR_ZERO} key_mode_t;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 cfg_wr_en        = 1'b0;
  logic                 cfg_wr_data      = 1'b0;
  logic                 start            = 1'b0;
  logic                 busy;
  logic                 in_command       = CMD_LOAD;
  logic [KEY_WIDTH-1:0] in_key_value     = '0;
  logic                 in_load_last     = 1'b0;
  logic                 out_strobe;
  logic [KEY_WIDTH-1:0] out_sorted_value;
  logic                 out_is_final;
  logic [1:0]           out_status;

  int fail_count;
  int pending_beats;
  int items_sent = 0;
  int burst_left = 0;

  always #5 clk = ~clk;

  quicksort_engine_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_key_value     (in_key_value),
    .in_load_last     (in_load_last),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_is_final     (out_is_final),
    .out_status       (out_status)
  );

  qse_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_key_value     (in_key_value),
    .in_load_last     (in_load_last),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_is_final     (out_is_final),
    .out_status       (out_status),
    .fail_count       (fail_count),
    .pending_beats    (pending_beats)
  );

  // Send one command beat. The sender works in bursts: when a burst runs
  // out, start drops while the payload ports carry junk, and a new
  // burst length is drawn. Most bursts are short, but some are
  // long so that back-to-back beats also get exercised. After acceptance
  // start is left high, so the next beat can follow on the very next cycle
  // without start being lowered and raised in the same time step.
  task automatic send_beat(input logic cmd, input logic [KEY_WIDTH-1:0] key,
                           input logic last);
    if (burst_left == 0) begin
      start        <= 1'b0;
      in_command   <= 1'($urandom_range(0, 1));
      in_key_value <= $urandom;
      in_load_last <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    start        <= 1'b1;
    in_command   <= cmd;
    in_key_value <= key;
    in_load_last <= last;
    // The beat is taken at the first edge that sees busy low; busy is a
    // registered output, so the value read here is the one before the edge.
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Drop start and wait until the engine has no sort running and every
  // predicted result beat has arrived. Every command yields a result, so
  // once nothing is pending the engine is truly idle.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // The key order register may only change while the engine is idle.
  task automatic write_key_order(input logic signed_mode);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= signed_mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  // Load a set of n keys, the final one marked last so that the sort starts.
  // The key patterns aim at different partition behavior: random spread,
  // heavy duplicates and sign-boundary values, runs that are already in
  // order or reversed, and small values on both sides of zero.
  task automatic load_set(input int n, input key_mode_t mode);
    logic [KEY_WIDTH-1:0] base;
    logic [KEY_WIDTH-1:0] stride;
    logic [KEY_WIDTH-1:0] k;
    base   = $urandom;
    stride = $urandom_range(1, 1000);
    for (int i = 0; i < n; i++) begin
      case (mode)
        KEYS_RANDOM: k = $urandom;
        KEYS_FEW: begin
          case ($urandom_range(0, 4))
            0:       k = 32'h0000_0000;
            1:       k = 32'hFFFF_FFFF;
            2:       k = 32'h8000_0000;
            3:       k = 32'h7FFF_FFFF;
            default: k = 32'h0000_0005;
          endcase
        end
        KEYS_RISING:  k = base + i * stride;
        KEYS_FALLING: k = base - i * stride;
        default:      k = $urandom_range(0, 64) - 32;
      endcase
      send_beat(CMD_LOAD, k, i == n - 1);
    end
  endtask

  // Reads ignore the key and last-flag ports, so those carry random bits.
  task automatic read_beats(input int count);
    repeat (count) send_beat(CMD_READ, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Unstructured traffic: random commands with the last flag set now and
  // then, so sorts start at odd points and reads hit partial sets.
  task automatic send_noise(input int count);
    repeat (count) begin
      send_beat(1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    int set_size;
    int read_count;

    // Reset is held low at the start and then released for good.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A read with no sorted set must report empty.
    read_beats(1);
    // Unsigned order with the extreme keys, read one past the end.
    send_beat(CMD_LOAD, 32'hFFFF_FFFF, 1'b0);
    send_beat(CMD_LOAD, 32'h0000_0000, 1'b0);
    send_beat(CMD_LOAD, 32'h8000_0000, 1'b0);
    send_beat(CMD_LOAD, 32'h7FFF_FFFF, 1'b0);
    send_beat(CMD_LOAD, 32'h0000_0001, 1'b1);
    read_beats(6);
    // Signed order; the first load here starts a fresh set.
    write_key_order(1'b1);
    send_beat(CMD_LOAD, 32'h8000_0000, 1'b0);
    send_beat(CMD_LOAD, 32'h7FFF_FFFF, 1'b0);
    send_beat(CMD_LOAD, 32'hFFFF_FFFF, 1'b0);
    send_beat(CMD_LOAD, 32'h0000_0000, 1'b1);
    // Leave the set half read, then replace it with a set of one key.
    read_beats(2);
    send_beat(CMD_LOAD, 32'h0000_0005, 1'b1);
    read_beats(2);
    // A read while a set is still being loaded is empty as well.
    send_beat(CMD_LOAD, 32'h0000_0003, 1'b0);
    read_beats(1);

    // Random part: mostly complete sets of random size and pattern, with
    // full or partial read-back, some noise, and key order changes between
    // sets. Sizes stay small so that sorts are quick.
    write_key_order(1'b0);
    while (items_sent < RANDOM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        write_key_order(1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 4) == 0) begin
        send_noise($urandom_range(4, 16));
      end else begin
        set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        load_set(set_size, key_mode_t'($urandom_range(0, 4)));
        if ($urandom_range(0, 4) == 0) begin
          read_count = $urandom_range(0, set_size);
        end else begin
          read_count = set_size + $urandom_range(0, 2);
        end
        read_beats(read_count);
      end
    end

    // Capacity: one full store of random signed keys read out completely,
    // then an overfull set of duplicate-heavy keys whose last-marked load is
    // itself dropped, partly read before a small set replaces it.
    write_key_order(1'b1);
    load_set(MAX_ELEMENTS, KEYS_RANDOM);
    read_beats(MAX_ELEMENTS + 1);
    write_key_order(1'b0);
    load_set(MAX_ELEMENTS + 2, KEYS_FEW);
    read_beats(30);
    load_set(3, KEYS_NEAR_ZERO);
    read_beats(4);

    // Drain: every command beat is in, now wait for the last result beats.
    start <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < DRAIN_LIMIT && (pending_beats != 0 || busy); w++) @(posedge clk);
    repeat (8) @(posedge clk);

    // A result beat that never arrived counts as a failure too.
    if (fail_count == 0 && pending_beats == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung engine: busy stuck high or a result beat lost.
  initial begin
    #(RUN_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

endmodule
